/* rtl/okss_pkg.sv */
// Package for the ordered key set core: sizes, action codes, sequencer
// states and bit scan functions. No dependencies.
`default_nettype none
package okss_pkg;
	localparam int KEY_W      = 16;
	localparam int WORD_W     = 64;
	localparam int POS_W      = 6;
	localparam int LEAF_WORDS = 1024;
	localparam int LEAF_AW    = 10;
	localparam int SUM_WORDS  = 16;
	localparam int SUM_AW     = 4;
	localparam int COUNT_W    = 17;

	localparam logic [2:0] ACT_INSERT   = 3'd0;
	localparam logic [2:0] ACT_REMOVE   = 3'd1;
	localparam logic [2:0] ACT_CONTAINS = 3'd2;
	localparam logic [2:0] ACT_LOWER    = 3'd3;
	localparam logic [2:0] ACT_UPPER    = 3'd4;

	typedef enum logic [2:0] {
		ST_CLEAR, ST_IDLE, ST_LEAF, ST_SRCH, ST_TAIL, ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		MODE_BOUND, MODE_MIN, MODE_MAX
	} mode_t;

	function automatic logic [POS_W-1:0] low_bit64(input logic [WORD_W-1:0] w);
		logic [POS_W-1:0] idx;
		idx = '0;
		for (int i = WORD_W - 1; i >= 0; i--) begin
			if (w[i]) idx = i[POS_W-1:0];
		end
		return idx;
	endfunction

	function automatic logic [POS_W-1:0] high_bit64(input logic [WORD_W-1:0] w);
		logic [POS_W-1:0] idx;
		idx = '0;
		for (int i = 0; i < WORD_W; i++) begin
			if (w[i]) idx = i[POS_W-1:0];
		end
		return idx;
	endfunction

	function automatic logic [SUM_AW-1:0] low_bit16(input logic [SUM_WORDS-1:0] w);
		logic [SUM_AW-1:0] idx;
		idx = '0;
		for (int i = SUM_WORDS - 1; i >= 0; i--) begin
			if (w[i]) idx = i[SUM_AW-1:0];
		end
		return idx;
	endfunction

	function automatic logic [SUM_AW-1:0] high_bit16(input logic [SUM_WORDS-1:0] w);
		logic [SUM_AW-1:0] idx;
		idx = '0;
		for (int i = 0; i < SUM_WORDS; i++) begin
			if (w[i]) idx = i[SUM_AW-1:0];
		end
		return idx;
	endfunction
endpackage
`default_nettype wire

/* rtl/ordered_key_set_successor_core.sv */
// Ordered key set with insert, remove, contains and successor search.
// An undefined action or an upper bound from the all-ones key goes straight to the done
// state; otherwise the leaf word is read and, if it does not settle the request, the
// summary and top levels are scanned and a leaf word found there is read in the tail state.
// No request is accepted until the last result is loaded into the output registers,
// which a stalled output delays. After reset a clearing pass zeroes all 1024 leaf words;
// no beat is accepted until it ends. Depends on okss_pkg and okss_ram.
`default_nettype none
module ordered_key_set_successor_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [2:0]  action,
	input  wire logic [15:0] key,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             ok,
	output logic      [15:0] result_key,
	output logic      [15:0] smallest,
	output logic      [15:0] largest,
	output logic      [16:0] member_count
);
	okss_pkg::state_t state_q, state_d;
	okss_pkg::mode_t  mode_q;

	logic [2:0]                     act_q;
	logic [okss_pkg::KEY_W-1:0]     key_q, min_q, max_q, res_q;
	logic [okss_pkg::COUNT_W-1:0]   cnt_q;
	logic                           ok_q;
	logic [okss_pkg::LEAF_AW-1:0]   l_q, clr_q;
	logic [okss_pkg::WORD_W-1:0]    sum_q [okss_pkg::SUM_WORDS];
	logic [okss_pkg::SUM_WORDS-1:0] top_q;
	logic                           out_valid_q;

	logic                           ram_we;
	logic [okss_pkg::LEAF_AW-1:0]   ram_waddr, ram_raddr;
	logic [okss_pkg::WORD_W-1:0]    ram_wdata, rdata;

	logic [okss_pkg::POS_W-1:0]     pos, sb, widx;
	logic [okss_pkg::LEAF_AW-1:0]   li, l_next;
	logic [okss_pkg::SUM_AW-1:0]    si, t_succ, t_high;
	logic [okss_pkg::WORD_W-1:0]    bitm, newleaf, scan_word, masked, sm;
	logic [okss_pkg::SUM_WORDS-1:0] tp;
	logic                           is_member, whit, l_found;
	logic [6:0]                     sb_p1;
	logic [4:0]                     si_p1;
	logic [okss_pkg::KEY_W-1:0]     tail_val, key_in;
	logic                           accept, out_load;

	okss_ram #(
		.WIDTH(okss_pkg::WORD_W),
		.DEPTH(okss_pkg::LEAF_WORDS)
	) u_leaf (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(rdata)
	);

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != okss_pkg::ST_IDLE);
	assign out_load = (state_q == okss_pkg::ST_DONE) && (!out_valid_q || !out_stall);

	always_comb begin
		key_in    = (action == okss_pkg::ACT_UPPER) ? key + 16'd1 : key;
		pos       = key_q[5:0];
		sb        = key_q[11:6];
		li        = key_q[15:6];
		si        = key_q[15:12];
		bitm      = 64'd1 << pos;
		is_member = |(rdata & bitm);
		newleaf   = rdata & ~bitm;
		scan_word = (act_q == okss_pkg::ACT_REMOVE) ? newleaf : rdata;
		masked    = scan_word & ({okss_pkg::WORD_W{1'b1}} << pos);
		whit      = |masked;
		widx      = okss_pkg::low_bit64(masked);
		sb_p1     = {1'b0, sb} + 7'd1;
		si_p1     = {1'b0, si} + 5'd1;
		sm        = sum_q[si] & ({okss_pkg::WORD_W{1'b1}} << sb_p1);
		tp        = top_q & ({okss_pkg::SUM_WORDS{1'b1}} << si_p1);
		t_succ    = okss_pkg::low_bit16(tp);
		t_high    = okss_pkg::high_bit16(top_q);
		if (mode_q == okss_pkg::MODE_MAX) begin
			l_found = 1'b1;
			l_next  = {t_high, okss_pkg::high_bit64(sum_q[t_high])};
		end else if (|sm) begin
			l_found = 1'b1;
			l_next  = {si, okss_pkg::low_bit64(sm)};
		end else begin
			l_found = |tp;
			l_next  = {t_succ, okss_pkg::low_bit64(sum_q[t_succ])};
		end
		tail_val = (mode_q == okss_pkg::MODE_MAX) ?
			{l_q, okss_pkg::high_bit64(rdata)} : {l_q, okss_pkg::low_bit64(rdata)};
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = li;
		ram_wdata = rdata | bitm;
		case (state_q)
			okss_pkg::ST_IDLE: ram_raddr = key_in[15:6];
			okss_pkg::ST_SRCH: ram_raddr = l_next;
			default:           ram_raddr = l_q;
		endcase
		case (state_q)
			okss_pkg::ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = '0;
			end
			okss_pkg::ST_LEAF: begin
				if (act_q == okss_pkg::ACT_INSERT && !is_member) begin
					ram_we = 1'b1;
				end else if (act_q == okss_pkg::ACT_REMOVE && is_member) begin
					ram_we    = 1'b1;
					ram_wdata = newleaf;
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			okss_pkg::ST_CLEAR: begin
				if (clr_q == okss_pkg::LEAF_AW'(okss_pkg::LEAF_WORDS - 1)) state_d = okss_pkg::ST_IDLE;
			end
			okss_pkg::ST_IDLE: begin
				if (accept) begin
					if (action > okss_pkg::ACT_UPPER) state_d = okss_pkg::ST_DONE;
					else if (action == okss_pkg::ACT_UPPER && key == 16'hFFFF)
						state_d = okss_pkg::ST_DONE;
					else state_d = okss_pkg::ST_LEAF;
				end
			end
			okss_pkg::ST_LEAF: begin
				state_d = okss_pkg::ST_DONE;
				if ((act_q == okss_pkg::ACT_LOWER || act_q == okss_pkg::ACT_UPPER) && !whit)
					state_d = okss_pkg::ST_SRCH;
				if (act_q == okss_pkg::ACT_REMOVE && is_member && cnt_q != 17'd1) begin
					if (key_q == min_q && !whit) state_d = okss_pkg::ST_SRCH;
					else if (key_q != min_q && key_q == max_q) state_d = okss_pkg::ST_SRCH;
				end
			end
			okss_pkg::ST_SRCH: state_d = l_found ? okss_pkg::ST_TAIL : okss_pkg::ST_DONE;
			okss_pkg::ST_TAIL: state_d = okss_pkg::ST_DONE;
			okss_pkg::ST_DONE: begin
				if (out_load) state_d = okss_pkg::ST_IDLE;
			end
			default: state_d = okss_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= okss_pkg::ST_CLEAR;
			clr_q       <= '0;
			cnt_q       <= '0;
			min_q       <= '1;
			max_q       <= '1;
			top_q       <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < okss_pkg::SUM_WORDS; i++) sum_q[i] <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == okss_pkg::ST_CLEAR) clr_q <= clr_q + 1'b1;
			if (out_load) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
			if (state_q == okss_pkg::ST_LEAF) begin
				if (act_q == okss_pkg::ACT_INSERT && !is_member) begin
					sum_q[si][sb] <= 1'b1;
					top_q[si]     <= 1'b1;
					cnt_q         <= cnt_q + 1'b1;
					if (cnt_q == '0 || key_q < min_q) min_q <= key_q;
					if (cnt_q == '0 || key_q > max_q) max_q <= key_q;
				end
				if (act_q == okss_pkg::ACT_REMOVE && is_member) begin
					cnt_q <= cnt_q - 1'b1;
					if (newleaf == '0) begin
						sum_q[si][sb] <= 1'b0;
						if ((sum_q[si] & ~(64'd1 << sb)) == '0) top_q[si] <= 1'b0;
					end
					if (cnt_q == 17'd1) begin
						min_q <= '1;
						max_q <= '1;
					end else if (key_q == min_q && whit) begin
						min_q <= {li, widx};
					end
				end
			end
			if (state_q == okss_pkg::ST_TAIL) begin
				if (mode_q == okss_pkg::MODE_MIN) min_q <= tail_val;
				if (mode_q == okss_pkg::MODE_MAX) max_q <= tail_val;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			act_q <= action;
			key_q <= key_in;
			ok_q  <= 1'b0;
			res_q <= (action == okss_pkg::ACT_LOWER || action == okss_pkg::ACT_UPPER) ?
				'1 : '0;
		end
		if (state_q == okss_pkg::ST_LEAF) begin
			if (act_q != okss_pkg::ACT_REMOVE) mode_q <= okss_pkg::MODE_BOUND;
			else if (key_q == min_q) mode_q <= okss_pkg::MODE_MIN;
			else mode_q <= okss_pkg::MODE_MAX;
			case (act_q)
				okss_pkg::ACT_INSERT:   ok_q <= !is_member;
				okss_pkg::ACT_REMOVE:   ok_q <= is_member;
				okss_pkg::ACT_CONTAINS: ok_q <= is_member;
				default: begin
					if (whit) begin
						ok_q  <= 1'b1;
						res_q <= {li, widx};
					end
				end
			endcase
		end
		if (state_q == okss_pkg::ST_SRCH) l_q <= l_next;
		if (state_q == okss_pkg::ST_TAIL && mode_q == okss_pkg::MODE_BOUND) begin
			ok_q  <= 1'b1;
			res_q <= tail_val;
		end
		if (out_load) begin
			ok           <= ok_q;
			result_key   <= res_q;
			smallest     <= min_q;
			largest      <= max_q;
			member_count <= cnt_q;
		end
	end

	assign out_valid = out_valid_q;

	a_empty_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == '0) |-> (min_q == 16'hFFFF && max_q == 16'hFFFF))
		else $error("empty set without cleared bounds");
	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q != '0 && state_q == okss_pkg::ST_IDLE) |-> (min_q <= max_q))
		else $error("minimum above maximum");
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 17'h10000)
		else $error("member count overflow");
	a_tail: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == okss_pkg::ST_TAIL) |-> ($past(state_q) == okss_pkg::ST_SRCH))
		else $error("leaf tail read without scan");
endmodule
`default_nettype wire

/* rtl/okss_ram.sv */
// Generic single write port, single read port RAM with registered read.
// No dependencies.
`default_nettype none
module okss_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

/* bench/okss_checker.sv */
// Checker for the ordered key set core: watches both channels, keeps its own
// copy of the key set and compares every result beat. Depends on okss_pkg.
`timescale 1ns / 100ps
module okss_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire logic        in_stall,
	input  wire logic [2:0]  action,
	input  wire logic [15:0] key,
	input  wire logic        out_valid,
	input  wire logic        out_stall,
	input  wire logic        ok,
	input  wire logic [15:0] result_key,
	input  wire logic [15:0] smallest,
	input  wire logic [15:0] largest,
	input  wire logic [16:0] member_count,
	output int               fail_count,
	output int               pending,
	output int               results_seen
);
	typedef struct packed {
		logic        ok;
		logic [15:0] rkey;
		logic [15:0] lo;
		logic [15:0] hi;
		logic [16:0] cnt;
	} answer_t;

	bit          in_set [0:65535];
	logic [15:0] set_lo, set_hi;
	logic [16:0] set_cnt;
	answer_t     answers [$];

	function automatic int next_member(int from);
		for (int k = from; k < 65536; k++)
			if (in_set[k]) return k;
		return -1;
	endfunction

	function automatic int last_member();
		for (int k = 65535; k >= 0; k--)
			if (in_set[k]) return k;
		return -1;
	endfunction

	function automatic answer_t apply_request(logic [2:0] act, logic [15:0] k);
		answer_t a;
		int s;
		a = '0;
		case (act)
		okss_pkg::ACT_INSERT: begin
			if (!in_set[k]) begin
				in_set[k] = 1;
				if (set_cnt == 0 || k < set_lo) set_lo = k;
				if (set_cnt == 0 || k > set_hi) set_hi = k;
				set_cnt++;
				a.ok = 1;
			end
		end
		okss_pkg::ACT_REMOVE: begin
			if (in_set[k]) begin
				in_set[k] = 0;
				set_cnt--;
				if (set_cnt == 0) begin
					set_lo = '1;
					set_hi = '1;
				end else begin
					if (k == set_lo) set_lo = 16'(next_member(k));
					if (k == set_hi) set_hi = 16'(last_member());
				end
				a.ok = 1;
			end
		end
		okss_pkg::ACT_CONTAINS: a.ok = in_set[k];
		okss_pkg::ACT_LOWER, okss_pkg::ACT_UPPER: begin
			a.rkey = '1;
			if (!(act == okss_pkg::ACT_UPPER && k == 16'hFFFF)) begin
				s = next_member(act == okss_pkg::ACT_UPPER ? int'(k) + 1 : int'(k));
				if (s >= 0) begin
					a.rkey = 16'(s);
					a.ok = 1;
				end
			end
		end
		default: ;
		endcase
		a.lo = set_lo;
		a.hi = set_hi;
		a.cnt = set_cnt;
		return a;
	endfunction

	initial begin
		foreach (in_set[i]) in_set[i] = 0;
		set_lo = '1;
		set_hi = '1;
		set_cnt = '0;
		fail_count = 0;
		results_seen = 0;
		pending = 0;
	end

	always @(posedge clk) begin
		answer_t want;
		if (arst_n && in_valid && !in_stall)
			answers.push_back(apply_request(action, key));
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (answers.size() == 0) begin
				$error("result beat with no request outstanding");
				fail_count++;
			end else begin
				want = answers.pop_front();
				if (ok !== want.ok) begin
					$error("ok: expected %0d, got %0d", want.ok, ok);
					fail_count++;
				end
				if (result_key !== want.rkey) begin
					$error("result_key: expected %h, got %h", want.rkey, result_key);
					fail_count++;
				end
				if (smallest !== want.lo) begin
					$error("smallest: expected %h, got %h", want.lo, smallest);
					fail_count++;
				end
				if (largest !== want.hi) begin
					$error("largest: expected %h, got %h", want.hi, largest);
					fail_count++;
				end
				if (member_count !== want.cnt) begin
					$error("member_count: expected %0d, got %0d", want.cnt, member_count);
					fail_count++;
				end
			end
		end
		pending = answers.size();
	end
endmodule

/* bench/tb_ordered_key_set_successor_core.sv */
// Testbench top for the ordered key set core: drives directed and random
// requests with random gaps and stalls. Depends on okss_pkg, okss_checker and the core.
`timescale 1ns / 100ps
module tb_ordered_key_set_successor_core;
	localparam int WATCHDOG_LIMIT = 5000;

	logic        clk, arst_n;
	logic        in_valid, in_stall;
	logic [2:0]  action;
	logic [15:0] key;
	logic        out_valid, out_stall;
	logic        ok;
	logic [15:0] result_key, smallest, largest;
	logic [16:0] member_count;
	int          fail_count, pending, results_seen;
	int          idle_cycles;
	int          requests_sent;
	bit          hold_off;
	bit          stim_done;
	logic [15:0] recent_keys [0:15];

	ordered_key_set_successor_core dut (.*);

	okss_checker u_checker (.*);

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic send(input logic [2:0] act, input logic [15:0] k);
		in_valid <= 1;
		action   <= act;
		key      <= k;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		recent_keys[requests_sent % 16] = k;
		requests_sent++;
	endtask

	task automatic pause(input int n);
		if (n > 0) begin
			in_valid <= 0;
			action   <= 3'($urandom);
			key      <= 16'($urandom);
			repeat (n) @(posedge clk);
		end
	endtask

	function automatic logic [15:0] pick_key();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40) return recent_keys[$urandom_range(0, 15)];
		if (r < 60) return 16'($urandom_range(0, 255));
		if (r < 70) return 16'($urandom_range(16'hFF00, 16'hFFFF));
		if (r < 80) return recent_keys[$urandom_range(0, 15)] + 16'($urandom_range(0, 2));
		return 16'($urandom);
	endfunction

	// Receiver: random stalls, with one long hold-off requested by the sender.
	initial begin
		int n;
		out_stall <= 1;
		@(posedge arst_n);
		forever begin
			if (hold_off) begin
				out_stall <= 1;
				repeat (200) @(posedge clk);
				hold_off = 0;
			end
			n = gap_len();
			out_stall <= (n > 0);
			repeat (n > 0 ? n : $urandom_range(1, 8)) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		wait (idle_cycles >= WATCHDOG_LIMIT);
		$display("watchdog: no beat accepted in %0d cycles", WATCHDOG_LIMIT);
		$display("tb_ordered_key_set_successor_core: done, errors");
		$finish;
	end

	initial begin
		logic [2:0] act;
		int r;
		idle_cycles   = -2000;
		requests_sent = 0;
		hold_off      = 0;
		stim_done     = 0;
		foreach (recent_keys[i]) recent_keys[i] = 16'(i);
		arst_n   = 0;
		in_valid = 0;
		action   = okss_pkg::ACT_INSERT;
		key      = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: empty set queries, extremes, duplicates, absent removes.
		send(okss_pkg::ACT_LOWER, 16'h0000);
		send(okss_pkg::ACT_UPPER, 16'hFFFF);
		send(okss_pkg::ACT_REMOVE, 16'h0005);
		send(okss_pkg::ACT_INSERT, 16'hFFFF);
		send(okss_pkg::ACT_INSERT, 16'h0000);
		send(okss_pkg::ACT_INSERT, 16'h0000);
		send(okss_pkg::ACT_CONTAINS, 16'hFFFF);
		send(okss_pkg::ACT_LOWER, 16'h0001);
		send(okss_pkg::ACT_UPPER, 16'hFFFE);
		send(okss_pkg::ACT_UPPER, 16'hFFFF);
		send(okss_pkg::ACT_INSERT, 16'h1040);
		send(okss_pkg::ACT_INSERT, 16'h103F);
		send(okss_pkg::ACT_UPPER, 16'h0000);
		send(okss_pkg::ACT_LOWER, 16'h1040);
		send(okss_pkg::ACT_REMOVE, 16'h0000);
		send(okss_pkg::ACT_REMOVE, 16'hFFFF);
		send(okss_pkg::ACT_CONTAINS, 16'h0000);
		send(okss_pkg::ACT_UPPER, 16'h1040);
		send(3'd5, 16'h1234);
		send(3'd7, 16'hFFFF);
		send(3'd6, 16'h0000);
		send(okss_pkg::ACT_REMOVE, 16'h1040);
		send(okss_pkg::ACT_REMOVE, 16'h103F);
		send(okss_pkg::ACT_LOWER, 16'h0000);

		// The sender pauses until every result is back.
		in_valid <= 0;
		do @(posedge clk); while (pending != 0);

		for (int i = 0; i < 900; i++) begin
			if (i == 300) hold_off = 1;
			r = $urandom_range(0, 99);
			if (r < 35) act = okss_pkg::ACT_INSERT;
			else if (r < 55) act = okss_pkg::ACT_REMOVE;
			else if (r < 67) act = okss_pkg::ACT_CONTAINS;
			else if (r < 80) act = okss_pkg::ACT_LOWER;
			else if (r < 95) act = okss_pkg::ACT_UPPER;
			else act = 3'($urandom_range(5, 7));
			send(act, pick_key());
			if (!hold_off) pause(gap_len());
		end
		in_valid <= 0;
		stim_done = 1;

		do @(posedge clk); while (pending != 0);
		repeat (20) @(posedge clk);
		$display("Sent %0d requests and checked %0d results, including a long output stall.",
			requests_sent, results_seen);
		if (fail_count == 0)
			$display("tb_ordered_key_set_successor_core: done, clean");
		else
			$display("tb_ordered_key_set_successor_core: done, errors");
		$finish;
	end
endmodule

/* ordered_key_set_successor_core.f */
rtl/okss_pkg.sv
rtl/okss_ram.sv
rtl/ordered_key_set_successor_core.sv
bench/okss_checker.sv
bench/tb_ordered_key_set_successor_core.sv
